FILE: sv/md4bc_pkg.sv
// Shared types, constants and table functions for the MD4 block compression core.
// Depends on nothing; the step unit, the top level and the testbench import it.
package md4bc_pkg;

   localparam int WORD_W    = 32;
   localparam int NUM_WORDS = 16;
   localparam int NUM_STEPS = 48;
   localparam int STEP_W    = 6;
   localparam int WIDX_W    = 4;
   localparam int SHIFT_W   = 5;
   localparam int CSR_IDX_W = 8;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [STEP_W-1:0]    step_type;
   typedef logic [WIDX_W-1:0]    widx_type;
   typedef logic [SHIFT_W-1:0]   shift_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   typedef enum logic [1:0] {
      ROUND_SEL = 2'd0,
      ROUND_MAJ = 2'd1,
      ROUND_PAR = 2'd2
   } round_type;

   // Register indexes of the configuration port.
   localparam csr_idx_type CSR_INIT_A = 8'd0;
   localparam csr_idx_type CSR_INIT_B = 8'd1;
   localparam csr_idx_type CSR_INIT_C = 8'd2;
   localparam csr_idx_type CSR_INIT_D = 8'd3;

   localparam word_type INIT_A_RST = 32'h6745_2301;
   localparam word_type INIT_B_RST = 32'hEFCD_AB89;
   localparam word_type INIT_C_RST = 32'h98BA_DCFE;
   localparam word_type INIT_D_RST = 32'h1032_5476;

   localparam word_type ROUND_ADD_SEL = 32'h0000_0000;
   localparam word_type ROUND_ADD_MAJ = 32'h5A82_7999;
   localparam word_type ROUND_ADD_PAR = 32'h6ED9_EBA1;

   // Control handed from the sequencer to the step unit.
   typedef struct packed {
      round_type round;
      shift_type shift;
      word_type  add_const;
   } step_ctl_type;

   // Schedule word used by a given step.
   function automatic widx_type word_index(input step_type step);
      widx_type j;
      widx_type k;
      j = step[3:0];
      case (step[5:4])
         2'd0:    k = j;
         2'd1:    k = {j[1:0], j[3:2]};
         2'd2:    k = {j[0], j[1], j[2], j[3]};
         default: k = j;
      endcase
      return k;
   endfunction

   function automatic step_ctl_type step_ctl(input step_type step);
      step_ctl_type ctl;
      logic [1:0]   pos;
      pos = step[1:0];
      ctl.round     = ROUND_SEL;
      ctl.add_const = ROUND_ADD_SEL;
      ctl.shift     = 5'd3;
      case (step[5:4])
         2'd0: begin
            ctl.round     = ROUND_SEL;
            ctl.add_const = ROUND_ADD_SEL;
            case (pos)
               2'd0:    ctl.shift = 5'd3;
               2'd1:    ctl.shift = 5'd7;
               2'd2:    ctl.shift = 5'd11;
               default: ctl.shift = 5'd19;
            endcase
         end
         2'd1: begin
            ctl.round     = ROUND_MAJ;
            ctl.add_const = ROUND_ADD_MAJ;
            case (pos)
               2'd0:    ctl.shift = 5'd3;
               2'd1:    ctl.shift = 5'd5;
               2'd2:    ctl.shift = 5'd9;
               default: ctl.shift = 5'd13;
            endcase
         end
         default: begin
            ctl.round     = ROUND_PAR;
            ctl.add_const = ROUND_ADD_PAR;
            case (pos)
               2'd0:    ctl.shift = 5'd3;
               2'd1:    ctl.shift = 5'd9;
               2'd2:    ctl.shift = 5'd11;
               default: ctl.shift = 5'd15;
            endcase
         end
      endcase
      return ctl;
   endfunction

endpackage

FILE: sv/md4bc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the sixteen-word message schedule.
module md4bc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/md4bc_step.sv
// One MD4 step: round function, four-operand add and left rotate.
// Depends on md4bc_pkg for the word and step control types.
module md4bc_step
   import md4bc_pkg::*;
(
   input  step_ctl_type ctl,
   input  word_type     a,
   input  word_type     b,
   input  word_type     c,
   input  word_type     d,
   input  word_type     x,
   output word_type     result
);

   word_type         f;
   word_type         sum;
   logic [SHIFT_W:0] back;

   always_comb begin
      case (ctl.round)
         ROUND_SEL: f = d ^ (b & (c ^ d));
         ROUND_MAJ: f = (b & c) | (d & (b | c));
         ROUND_PAR: f = b ^ c ^ d;
         default:   f = b ^ c ^ d;
      endcase
   end

   assign sum    = a + f + x + ctl.add_const;
   // Rotate amounts are never zero, so the right shift stays below the word width.
   assign back   = 6'd32 - {1'b0, ctl.shift};
   assign result = (sum << ctl.shift) | (sum >> back);

endmodule

FILE: sv/md4_block_compress_top.sv
// Top level of the MD4 block compression core: schedule store, step sequencer,
// chaining value and the three ports. Depends on md4bc_pkg, md4bc_ram, md4bc_step.
//
//  Port  | Direction | Carries
//  ------+-----------+-----------------------------------------------------
//  req_  | in        | one 32-bit message word and the first-block flag
//  rsp_  | out       | the four updated chaining words after sixteen words
//  csr_  | in        | writes of the four initial chaining words (index 0-3)
//
// A word that is not the sixteenth of its block is taken as soon as it is offered
// while the core is idle. After the sixteenth word the block is busy: ST_PRIME
// loads the working words and primes the schedule read, ST_RUN has the single
// step unit run the 48 MD4 steps one after another, and ST_FINAL does the final
// chaining add. No word is taken while the block is busy.
// Reset is synchronous and active high; it restores the initial words to the
// standard MD4 values and clears the chaining value and word count.
// While a result waits on rsp_ready, words 1 to 15 of the next block are still
// accepted; the sixteenth word is held off until the result has been taken.
module md4_block_compress_top
   import md4bc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_msg_word,
   input  logic        req_first_block,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_a,
   output logic [31:0] rsp_digest_b,
   output logic [31:0] rsp_digest_c,
   output logic [31:0] rsp_digest_d,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PRIME = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_FINAL = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   widx_type  word_count_ff, word_count_in;
   logic      start_flag_ff, start_flag_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;

   word_type  init_a_ff, init_a_in;
   word_type  init_b_ff, init_b_in;
   word_type  init_c_ff, init_c_in;
   word_type  init_d_ff, init_d_in;

   word_type  chain_a_ff, chain_a_in;
   word_type  chain_b_ff, chain_b_in;
   word_type  chain_c_ff, chain_c_in;
   word_type  chain_d_ff, chain_d_in;

   word_type  work_a_ff, work_a_in;
   word_type  work_b_ff, work_b_in;
   word_type  work_c_ff, work_c_in;
   word_type  work_d_ff, work_d_in;

   logic         req_take;
   logic         csr_take;
   widx_type     rd_addr;
   word_type     sched_word;
   word_type     step_result;
   step_ctl_type ctl;
   step_type     step_next;

   // The sixteenth word starts a compression, which would overwrite the
   // chaining value a pending result still shows.
   assign req_ready = (state_ff == ST_IDLE) &&
                      !((word_count_ff == 4'(NUM_WORDS - 1)) && rsp_valid_ff);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   // The schedule read is registered, so the address runs one step ahead of
   // the step that consumes the word.
   assign step_next = step_ff + 6'd1;
   assign rd_addr   = (state_ff == ST_PRIME) ? word_index('0) : word_index(step_next);
   assign ctl       = step_ctl(step_ff);

   md4bc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_WORDS)
   ) u_sched (
      .clock   (clock),
      .wr_en   (req_take),
      .wr_addr (word_count_ff),
      .wr_data (req_msg_word),
      .rd_addr (rd_addr),
      .rd_data (sched_word)
   );

   md4bc_step u_step (
      .ctl    (ctl),
      .a      (work_a_ff),
      .b      (work_b_ff),
      .c      (work_c_ff),
      .d      (work_d_ff),
      .x      (sched_word),
      .result (step_result)
   );

   always_comb begin
      state_in      = state_ff;
      word_count_in = word_count_ff;
      start_flag_in = start_flag_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      init_a_in     = init_a_ff;
      init_b_in     = init_b_ff;
      init_c_in     = init_c_ff;
      init_d_in     = init_d_ff;
      chain_a_in    = chain_a_ff;
      chain_b_in    = chain_b_ff;
      chain_c_in    = chain_c_ff;
      chain_d_in    = chain_d_ff;
      work_a_in     = work_a_ff;
      work_b_in     = work_b_ff;
      work_c_in     = work_c_ff;
      work_d_in     = work_d_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Writes to indexes outside the register list are dropped.
      if (csr_take) begin
         case (csr_index)
            CSR_INIT_A: init_a_in = csr_wdata;
            CSR_INIT_B: init_b_in = csr_wdata;
            CSR_INIT_C: init_c_in = csr_wdata;
            CSR_INIT_D: init_d_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // The flag only counts with the first word of a block.
               if (word_count_ff == '0) begin
                  start_flag_in = req_first_block;
               end
               if (word_count_ff == 4'(NUM_WORDS - 1)) begin
                  word_count_in = '0;
                  state_in      = ST_PRIME;
               end else begin
                  word_count_in = word_count_ff + 4'd1;
               end
            end
         end
         ST_PRIME: begin
            // The chaining registers hold the base until the final add.
            if (start_flag_ff) begin
               chain_a_in = init_a_ff;
               chain_b_in = init_b_ff;
               chain_c_in = init_c_ff;
               chain_d_in = init_d_ff;
            end
            work_a_in = start_flag_ff ? init_a_ff : chain_a_ff;
            work_b_in = start_flag_ff ? init_b_ff : chain_b_ff;
            work_c_in = start_flag_ff ? init_c_ff : chain_c_ff;
            work_d_in = start_flag_ff ? init_d_ff : chain_d_ff;
            step_in   = '0;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            // Rotating the working words puts the updated word in slot B's place
            // for the next step; after 48 steps the order is restored.
            work_a_in = work_d_ff;
            work_b_in = step_result;
            work_c_in = work_b_ff;
            work_d_in = work_c_ff;
            step_in   = step_next;
            if (step_ff == 6'(NUM_STEPS - 1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            chain_a_in   = chain_a_ff + work_a_ff;
            chain_b_in   = chain_b_ff + work_b_ff;
            chain_c_in   = chain_c_ff + work_c_ff;
            chain_d_in   = chain_d_ff + work_d_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         word_count_ff <= '0;
         start_flag_ff <= 1'b0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         init_a_ff     <= INIT_A_RST;
         init_b_ff     <= INIT_B_RST;
         init_c_ff     <= INIT_C_RST;
         init_d_ff     <= INIT_D_RST;
         chain_a_ff    <= '0;
         chain_b_ff    <= '0;
         chain_c_ff    <= '0;
         chain_d_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         word_count_ff <= word_count_in;
         start_flag_ff <= start_flag_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
         init_a_ff     <= init_a_in;
         init_b_ff     <= init_b_in;
         init_c_ff     <= init_c_in;
         init_d_ff     <= init_d_in;
         chain_a_ff    <= chain_a_in;
         chain_b_ff    <= chain_b_in;
         chain_c_ff    <= chain_c_in;
         chain_d_ff    <= chain_d_in;
      end
   end

   always_ff @(posedge clock) begin
      work_a_ff <= work_a_in;
      work_b_ff <= work_b_in;
      work_c_ff <= work_c_in;
      work_d_ff <= work_d_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_digest_a = chain_a_ff;
   assign rsp_digest_b = chain_b_ff;
   assign rsp_digest_c = chain_c_ff;
   assign rsp_digest_d = chain_d_ff;

endmodule

FILE: sv/md4bc_chk.sv
// Port-level checker for the MD4 block compression core, bound to the top level.
// Depends only on the top level's ports.
module md4bc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_a,
   input logic [31:0] rsp_digest_b,
   input logic [31:0] rsp_digest_c,
   input logic [31:0] rsp_digest_d
);

   // A result that is not taken stays, with its digest unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_a) &&
         $stable(rsp_digest_b) && $stable(rsp_digest_c) && $stable(rsp_digest_d))
      else $error("result dropped or changed while stalled");

   // A result only appears after the block has been busy compressing.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready) && !$past(req_ready, 2))
      else $error("result appeared without a compression");

   // While the final chaining add runs, no request is taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("request accepted during compression");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind md4_block_compress_top md4bc_chk u_md4bc_chk (.*);

FILE: test/md4_block_compress_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for md4_block_compress_top: drives message words and
// register writes, predicts each digest in SystemVerilog and compares. Depends on md4bc_pkg.
module md4_block_compress_top_tb
   import md4bc_pkg::*;
();

   // A full block keeps the core busy after its sixteenth word; this many
   // idle cycles are enough to see it settle.
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_REPORTS  = 10;
   localparam int RANDOM_BLOCKS = 112;

   // An index beyond the four initial words; the core is expected to ignore it.
   localparam csr_idx_type CSR_SPARE_IDX = 8'hFF;

   // Patterns for the response side back-pressure.
   typedef enum logic [1:0] {
      RX_EAGER,
      RX_CHOPPY,
      RX_SLUGGISH
   } rx_pattern_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } digest_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_msg_word;
   logic        req_first_block;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_a;
   logic [31:0] rsp_digest_b;
   logic [31:0] rsp_digest_c;
   logic [31:0] rsp_digest_d;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_wdata;

   md4_block_compress_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_msg_word    (req_msg_word),
      .req_first_block (req_first_block),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_a    (rsp_digest_a),
      .rsp_digest_b    (rsp_digest_b),
      .rsp_digest_c    (rsp_digest_c),
      .rsp_digest_d    (rsp_digest_d),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Clock with a 4 ns period.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Digest predictor. It keeps its own copy of the schedule, the word
   // position inside the block, the chaining value and the four initial
   // words, and is updated at every accepted request and register write.
   // ------------------------------------------------------------------
   word_type   init_words [4];
   word_type   sched      [16];
   logic [3:0] word_pos;
   word_type   chain      [4];
   logic       chain_restart;

   digest_type expected_digests [$];

   int words_sent;
   int digests_checked;
   int csr_writes;
   int mismatches;

   // Receiver and sender shaping, changed by the tests as they go.
   rx_pattern_type rx_pattern;
   int             rx_stall_left;
   bit             gaps_on;
   int             burst_left;

   function automatic void reset_predictor();
      init_words[0] = INIT_A_RST;
      init_words[1] = INIT_B_RST;
      init_words[2] = INIT_C_RST;
      init_words[3] = INIT_D_RST;
      for (int i = 0; i < 16; i++) sched[i] = '0;
      for (int i = 0; i < 4; i++) chain[i] = '0;
      word_pos      = '0;
      chain_restart = 1'b0;
   endfunction

   // Runs the 48 MD4 steps over the held schedule and folds the working
   // words into the chaining value.
   function automatic void compress_block();
      word_type   start [4];
      word_type   v     [4];
      word_type   f;
      word_type   acc;
      word_type   xb;
      word_type   xc;
      word_type   xd;
      word_type   add;
      int         r;
      int         j;
      int         t;
      int         k;
      int         s;
      logic [3:0] jv;
      for (int i = 0; i < 4; i++) start[i] = chain_restart ? init_words[i] : chain[i];
      v = start;
      for (int step = 0; step < 48; step++) begin
         r  = step / 16;
         j  = step % 16;
         jv = j;
         t  = (4 - (j % 4)) % 4;
         xb = v[(t + 1) % 4];
         xc = v[(t + 2) % 4];
         xd = v[(t + 3) % 4];
         case (r)
            0: begin
               f   = (xb & xc) | (~xb & xd);
               k   = j;
               add = ROUND_ADD_SEL;
               s   = (j % 4 == 0) ? 3 : (j % 4 == 1) ? 7 : (j % 4 == 2) ? 11 : 19;
            end
            1: begin
               f   = (xb & xc) | (xb & xd) | (xc & xd);
               k   = (j % 4) * 4 + j / 4;
               add = ROUND_ADD_MAJ;
               s   = (j % 4 == 0) ? 3 : (j % 4 == 1) ? 5 : (j % 4 == 2) ? 9 : 13;
            end
            default: begin
               f   = xb ^ xc ^ xd;
               k   = {jv[0], jv[1], jv[2], jv[3]};
               add = ROUND_ADD_PAR;
               s   = (j % 4 == 0) ? 3 : (j % 4 == 1) ? 9 : (j % 4 == 2) ? 11 : 15;
            end
         endcase
         acc  = v[t] + f + sched[k] + add;
         v[t] = (acc << s) | (acc >> (32 - s));
      end
      for (int i = 0; i < 4; i++) chain[i] = start[i] + v[i];
   endfunction

   // Takes one accepted message word; on the sixteenth word of a block it
   // queues the digest the core should return.
   function automatic void predict_word(input word_type w, input logic flag);
      digest_type dg;
      // The first-block flag only counts on the opening word of a block.
      if (word_pos == 4'd0) chain_restart = flag;
      sched[word_pos] = w;
      if (word_pos != 4'd15) begin
         word_pos = word_pos + 4'd1;
         return;
      end
      word_pos = 4'd0;
      compress_block();
      dg.a = chain[0];
      dg.b = chain[1];
      dg.c = chain[2];
      dg.d = chain[3];
      expected_digests.push_back(dg);
   endfunction

   function automatic void apply_csr(input csr_idx_type idx, input word_type value);
      case (idx)
         CSR_INIT_A: init_words[0] = value;
         CSR_INIT_B: init_words[1] = value;
         CSR_INIT_C: init_words[2] = value;
         CSR_INIT_D: init_words[3] = value;
         default:    ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Monitor and checker. Everything is sampled at the rising edge, before
   // the core's own updates for that edge take effect, so the values seen
   // are those the handshake actually used. The digest check runs before
   // the prediction so a result leaving and a block ending on the same edge
   // keep their order.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      digest_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digests.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: digest %h %h %h %h arrived with none expected", $realtime,
                           rsp_digest_a, rsp_digest_b, rsp_digest_c, rsp_digest_d);
            end else begin
               want = expected_digests.pop_front();
               digests_checked++;
               if (rsp_digest_a !== want.a || rsp_digest_b !== want.b ||
                   rsp_digest_c !== want.c || rsp_digest_d !== want.d) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: digest mismatch, expected %h %h %h %h, got %h %h %h %h",
                              $realtime, want.a, want.b, want.c, want.d, rsp_digest_a,
                              rsp_digest_b, rsp_digest_c, rsp_digest_d);
               end
            end
         end
         if (req_valid && req_ready) begin
            words_sent++;
            predict_word(req_msg_word, req_first_block);
         end
         if (csr_valid && csr_ready) begin
            csr_writes++;
            apply_csr(csr_index, csr_wdata);
         end
      end
   end

   // Response back-pressure. Whenever a stall has run out, the choppy and sluggish
   // patterns decide whether to start another and how long it lasts; eager starts none.
   always @(negedge clock) begin
      if (rx_stall_left > 0) begin
         rsp_ready     <= 1'b0;
         rx_stall_left <= rx_stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         case (rx_pattern)
            RX_CHOPPY:
               if ($urandom_range(0, 2) == 0) rx_stall_left <= $urandom_range(1, 4);
            RX_SLUGGISH:
               if ($urandom_range(0, 1) == 0) rx_stall_left <= $urandom_range(5, 40);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Drivers. Inputs change only at the falling edge.
   // ------------------------------------------------------------------

   // Presents one request and holds it until the core takes it. Valid is
   // left high so the next request can follow without a bubble.
   task automatic send_word(input word_type w, input logic flag);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_msg_word    <= w;
      req_first_block <= flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Sends a request as part of a burst; between bursts the sender idles for
   // a random number of cycles when gaps are enabled.
   task automatic feed_word(input word_type w, input logic flag);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            gap = $urandom_range(1, 8);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      send_word(w, flag);
   endtask

   // Stops sending and waits until every predicted digest has been returned,
   // then lets the core settle.
   task automatic wait_for_digests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_digests.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input word_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_init_words(input word_type a, input word_type b,
                                  input word_type c, input word_type d);
      csr_write(CSR_INIT_A, a);
      csr_write(CSR_INIT_B, b);
      csr_write(CSR_INIT_C, c);
      csr_write(CSR_INIT_D, d);
   endtask

   // Message word with a bias toward the field extremes and single set bits.
   function automatic word_type pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Right after reset, a block without the first-block flag continues from
   // a chaining value of zero. The words sweep the field extremes.
   task automatic test_unchained_start();
      for (int i = 0; i < 16; i++) begin
         case (i % 4)
            0: send_word(32'h0000_0000, 1'b0);
            1: send_word(32'hFFFF_FFFF, 1'b0);
            2: send_word(32'h8000_0001, 1'b0);
            default: send_word(32'h1 << i, 1'b0);
         endcase
      end
      wait_for_digests();
   endtask

   // The flag counts only with the first word of a block: a block that opens
   // with it set starts from the reset initial words whatever follows, and a
   // block that opens with it clear keeps chaining even if later words set it.
   task automatic test_flag_sampling();
      for (int i = 0; i < 16; i++) send_word($urandom, (i == 0));
      for (int i = 0; i < 16; i++) send_word($urandom, (i != 0));
      wait_for_digests();
   endtask

   // Initial words written part way through a block apply to that block,
   // since they are only read when the block is compressed.
   task automatic test_midblock_write();
      for (int i = 0; i < 7; i++) send_word(pick_word(), 1'b1);
      wait_for_digests();
      load_init_words(32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h8000_0001);
      for (int i = 7; i < 16; i++) send_word(pick_word(), 1'b0);
      wait_for_digests();
   endtask

   // Extreme and random initial words, each used by a two-block chain. A
   // write to an index with no register behind it must change nothing.
   task automatic test_init_extremes();
      for (int setting = 0; setting < 3; setting++) begin
         case (setting)
            0: load_init_words('0, '0, '0, '0);
            1: load_init_words('1, '1, '1, '1);
            default: load_init_words($urandom, $urandom, $urandom, $urandom);
         endcase
         csr_write(CSR_SPARE_IDX, $urandom);
         for (int blk = 0; blk < 2; blk++)
            for (int i = 0; i < 16; i++) send_word(pick_word(), (blk == 0 && i == 0));
         wait_for_digests();
      end
   endtask

   // Chains of one to four blocks with random content. Most chains open with
   // the flag set; a few leave it clear or set it in mid-chain. Every so often
   // the sender stops, waits for all digests, and a new register setting is
   // loaded. Sender gaps and the receiver pattern change as the run goes on.
   task automatic test_random_chains();
      int   chain_left;
      logic opener;
      logic flag;
      chain_left = 0;
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         if (blk % 20 == 0) begin
            rx_pattern = rx_pattern_type'($urandom_range(0, 2));
            gaps_on    = ($urandom_range(0, 3) != 0);
         end
         if (blk % 25 == 24) begin
            wait_for_digests();
            case ($urandom_range(0, 3))
               0: load_init_words(INIT_A_RST, INIT_B_RST, INIT_C_RST, INIT_D_RST);
               1: load_init_words('0, '1, '0, '1);
               default: load_init_words($urandom, $urandom, $urandom, $urandom);
            endcase
         end
         opener = 1'b0;
         if (chain_left == 0) begin
            chain_left = $urandom_range(1, 4);
            opener     = 1'b1;
         end
         chain_left--;
         // One block in ten gets the flag opposite to a clean chain.
         flag = ($urandom_range(0, 9) == 0) ? !opener : opener;
         for (int i = 0; i < 16; i++)
            feed_word(pick_word(), (i == 0) ? flag : 1'($urandom_range(0, 1)));
      end
      wait_for_digests();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_msg_word    = '0;
      req_first_block = 1'b0;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      rx_pattern      = RX_EAGER;
      rx_stall_left   = 0;
      gaps_on         = 1'b0;
      burst_left      = 0;
      words_sent      = 0;
      digests_checked = 0;
      csr_writes      = 0;
      mismatches      = 0;
      reset_predictor();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unchained_start();
      rx_pattern = RX_CHOPPY;
      test_flag_sampling();
      test_midblock_write();
      rx_pattern = RX_SLUGGISH;
      test_init_extremes();
      test_random_chains();

      $display("Sent %0d message words and %0d register writes; checked %0d digests",
               words_sent, csr_writes, digests_checked);
      $display("over chained and restarted blocks, extreme initial words and mixed stalls.");
      if (mismatches == 0 && expected_digests.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Guard against a hang: far beyond the slowest legal run.
   initial begin
      #1000000;
      $display("Timed out with %0d digests outstanding", expected_digests.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
sv/md4bc_pkg.sv
sv/md4bc_ram.sv
sv/md4bc_step.sv
sv/md4_block_compress_top.sv
sv/md4bc_chk.sv
test/md4_block_compress_top_tb.sv
